@@ rtl/mshs_pkg.sv @@
// shared types, codes and defaults for the mount slew and homing sequencer
package mshs_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [15:0] FAST_POLL_RST   = 16'd500;
    localparam logic [15:0] SLOW_POLL_RST   = 16'd250;
    localparam logic [3:0]  FAST_RATE_RST   = 4'd9;
    localparam logic [3:0]  MEDIUM_RATE_RST = 4'd6;
    localparam logic [3:0]  SLOW_RATE_RST   = 4'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FAST_POLL   = 3'd0,
        REG_SLOW_POLL   = 3'd1,
        REG_FAST_RATE   = 3'd2,
        REG_MEDIUM_RATE = 3'd3,
        REG_SLOW_RATE   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_GOTO  = 2'd1,
        MODE_ABORT = 2'd2,
        MODE_HOME  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE        = 2'd0,
        KIND_POLE_FAST   = 2'd1,
        KIND_TARGET_FAST = 2'd2,
        KIND_TARGET_SLOW = 2'd3
    } goto_kind_t;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_FLIP  = 9'b000000010,
        PH_FAST  = 9'b000000100,
        PH_SLOW  = 9'b000001000,
        PH_DSEEK = 9'b000010000,
        PH_F1    = 9'b000100000,
        PH_F2    = 9'b001000000,
        PH_S1    = 9'b010000000,
        PH_S2    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [15:0] fast_poll_ms;
        logic [15:0] slow_poll_ms;
        logic [3:0]  fast_rate;
        logic [3:0]  medium_rate;
        logic [3:0]  slow_rate;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        flip_needed;
        logic        slew_done;
        logic        position_synced;
        logic        dec_blocked;
        logic        ra_blocked;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   ra_done;
        logic   dec_stop;
        logic   seek_dir;
        logic   aligned;
    } ctl_t;

    typedef struct packed {
        logic       dec_cmd_valid;
        logic       dec_dir;
        logic [3:0] dec_rate;
        logic       ra_cmd_valid;
        logic       ra_dir;
        logic [3:0] ra_rate;
        logic [1:0] goto_kind;
        logic       set_home;
        logic       busy_res;
        logic       is_aligned;
        logic [3:0] phase;
    } res_t;

    function automatic logic [3:0] phase_code(input phase_t ph);
        logic [3:0] code;
        code = 4'd0;
        case (ph)
            PH_IDLE:  code = 4'd0;
            PH_FLIP:  code = 4'd1;
            PH_FAST:  code = 4'd2;
            PH_SLOW:  code = 4'd3;
            PH_DSEEK: code = 4'd4;
            PH_F1:    code = 4'd5;
            PH_F2:    code = 4'd6;
            PH_S1:    code = 4'd7;
            PH_S2:    code = 4'd8;
            default:  code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/mshs_cfg.sv @@
// configuration register file for poll intervals and axis rates
module mshs_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mshs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mshs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output mshs_pkg::cfg_t                      cfg
);
    import mshs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_poll_ms <= FAST_POLL_RST;
            cfg_reg.slow_poll_ms <= SLOW_POLL_RST;
            cfg_reg.fast_rate    <= FAST_RATE_RST;
            cfg_reg.medium_rate  <= MEDIUM_RATE_RST;
            cfg_reg.slow_rate    <= SLOW_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FAST_POLL:   cfg_reg.fast_poll_ms <= cfg_wdata;
                REG_SLOW_POLL:   cfg_reg.slow_poll_ms <= cfg_wdata;
                REG_FAST_RATE:   cfg_reg.fast_rate    <= cfg_wdata[3:0];
                REG_MEDIUM_RATE: cfg_reg.medium_rate  <= cfg_wdata[3:0];
                REG_SLOW_RATE:   cfg_reg.slow_rate    <= cfg_wdata[3:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/mshs_step.sv @@
// next-state and result logic for one polled request
module mshs_step #(
    parameter int TIME_BITS = mshs_pkg::TIME_BITS_DEF
) (
    input  mshs_pkg::item_t         item,
    input  mshs_pkg::cfg_t          cfg,
    input  mshs_pkg::ctl_t          ctl,
    input  logic [TIME_BITS-1:0]    timer,
    output mshs_pkg::ctl_t          ctl_next,
    output logic [TIME_BITS-1:0]    timer_next,
    output mshs_pkg::res_t          res
);
    import mshs_pkg::*;

    localparam int NOW_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [NOW_W-1:0]     now_w;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fast_poll_hit;
    logic                 slow_poll_hit;

    // per-pass settings
    logic                 want_blocked;
    logic                 next_dir;
    logic [3:0]           next_rate;
    phase_t               next_phase;
    logic                 finish;

    logic                 dec_hit;
    logic                 ra_hit;
    logic                 dec_stop_n;
    logic                 ra_done_n;

    ctl_t                 c;
    logic                 d_v;
    logic                 d_d;
    logic [3:0]           d_r;
    logic                 r_v;
    logic                 r_d;
    logic [3:0]           r_r;
    logic [1:0]           kind;
    logic                 home;

    assign now_w         = NOW_W'(item.now_ms);
    assign now_t         = now_w[TIME_BITS-1:0];
    assign elapsed       = now_t - timer;
    assign fast_poll_hit = elapsed > TIME_BITS'(cfg.fast_poll_ms);
    assign slow_poll_hit = elapsed > TIME_BITS'(cfg.slow_poll_ms);

    always_comb
    begin
        want_blocked = 1'b0;
        next_dir     = 1'b0;
        next_rate    = 4'd0;
        next_phase   = PH_IDLE;
        finish       = 1'b0;
        case (ctl.phase)
            PH_F1:
            begin
                want_blocked = 1'b0;
                next_dir     = 1'b1;
                next_rate    = cfg.fast_rate;
                next_phase   = PH_F2;
            end
            PH_F2:
            begin
                want_blocked = 1'b1;
                next_dir     = 1'b0;
                next_rate    = cfg.medium_rate;
                next_phase   = PH_S1;
            end
            PH_S1:
            begin
                want_blocked = 1'b0;
                next_dir     = 1'b1;
                next_rate    = cfg.slow_rate;
                next_phase   = PH_S2;
            end
            PH_S2:
            begin
                want_blocked = 1'b1;
                finish       = 1'b1;
            end
            default: ;
        endcase
    end

    assign dec_hit    = !ctl.dec_stop && (item.dec_blocked == want_blocked);
    assign ra_hit     = !ctl.ra_done && (item.ra_blocked == want_blocked);
    assign dec_stop_n = ctl.dec_stop || dec_hit;
    assign ra_done_n  = ctl.ra_done || ra_hit;

    always_comb
    begin
        c          = ctl;
        timer_next = timer;
        d_v        = 1'b0;
        d_d        = 1'b0;
        d_r        = 4'd0;
        r_v        = 1'b0;
        r_d        = 1'b0;
        r_r        = 4'd0;
        kind       = KIND_NONE;
        home       = 1'b0;

        if (item.mode == MODE_ABORT)
        begin
            d_v     = 1'b1;
            r_v     = 1'b1;
            c.phase = PH_IDLE;
        end
        else
        begin
            case (ctl.phase)
                PH_FLIP, PH_FAST:
                begin
                    if (fast_poll_hit)
                    begin
                        timer_next = now_t;
                        if (item.slew_done)
                        begin
                            if (ctl.phase == PH_FLIP)
                            begin
                                if (item.position_synced)
                                    kind = KIND_TARGET_FAST;
                                c.phase = PH_FAST;
                            end
                            else
                            begin
                                if (item.position_synced)
                                    kind = KIND_TARGET_SLOW;
                                c.phase = PH_SLOW;
                            end
                        end
                    end
                end
                PH_SLOW:
                begin
                    if (slow_poll_hit)
                    begin
                        timer_next = now_t;
                        if (item.slew_done)
                            c.phase = PH_IDLE;
                    end
                end
                PH_DSEEK:
                begin
                    if (ctl.seek_dir == item.dec_blocked)
                    begin
                        d_v        = 1'b1;
                        d_r        = cfg.fast_rate;
                        r_v        = 1'b1;
                        r_r        = cfg.fast_rate;
                        c.ra_done  = 1'b0;
                        c.dec_stop = 1'b0;
                        c.phase    = PH_F1;
                    end
                end
                PH_F1, PH_F2, PH_S1, PH_S2:
                begin
                    // stop each axis on its sensor edge
                    if (dec_hit)
                        d_v = 1'b1;
                    if (ra_hit)
                        r_v = 1'b1;
                    c.dec_stop = dec_stop_n;
                    c.ra_done  = ra_done_n;
                    if (dec_stop_n && ra_done_n)
                    begin
                        if (finish)
                        begin
                            home      = 1'b1;
                            c.aligned = 1'b1;
                            c.phase   = PH_IDLE;
                        end
                        else
                        begin
                            c.ra_done  = 1'b0;
                            c.dec_stop = 1'b0;
                            d_v        = 1'b1;
                            d_d        = next_dir;
                            d_r        = next_rate;
                            r_v        = 1'b1;
                            r_d        = next_dir;
                            r_r        = next_rate;
                            c.phase    = next_phase;
                        end
                    end
                end
                default:
                begin
                    c.phase = PH_IDLE;
                    if (item.mode == MODE_GOTO)
                    begin
                        timer_next = now_t;
                        if (item.flip_needed)
                        begin
                            if (item.position_synced)
                                kind = KIND_POLE_FAST;
                            c.phase = PH_FLIP;
                        end
                        else
                        begin
                            if (item.position_synced)
                                kind = KIND_TARGET_FAST;
                            c.phase = PH_FAST;
                        end
                    end
                    else if (item.mode == MODE_HOME)
                    begin
                        c.seek_dir = !item.dec_blocked;
                        d_v        = 1'b1;
                        d_d        = !item.dec_blocked;
                        d_r        = cfg.fast_rate;
                        c.aligned  = 1'b0;
                        c.phase    = PH_DSEEK;
                    end
                end
            endcase
        end
    end

    assign ctl_next = c;

    always_comb
    begin
        res.dec_cmd_valid = d_v;
        res.dec_dir       = d_d;
        res.dec_rate      = d_r;
        res.ra_cmd_valid  = r_v;
        res.ra_dir        = r_d;
        res.ra_rate       = r_r;
        res.goto_kind     = kind;
        res.set_home      = home;
        res.busy_res      = (c.phase != PH_IDLE);
        res.is_aligned    = c.aligned;
        res.phase         = phase_code(c.phase);
    end

endmodule

@@ rtl/mount_slew_and_homing_sequencer.sv @@
// top level: request register, sequencer state, result register
//
// A two-axis mount sequencer polled once per request. The input channel
// (in_valid / in_ready) carries a command, status flags, the two home
// sensor levels and a millisecond time. The output channel (out_valid /
// out_ready) carries one result per request: the last move command for
// each axis, the goto kind, a set-home pulse and the phase after the step.
// A request is registered on acceptance and passes through the step logic
// into the result register once the result slot is free, and its result
// is offered from there. One request per clock is taken while out_ready
// stays high; the step logic is a single pass of compares and muxes.
// A stalled receiver holds the result register and the request register
// then fills, after which in_ready drops; nothing is lost or repeated.
// Reset clears the sequencer to idle, not aligned, timer zero, and loads
// the default poll intervals and rates. Configuration writes take effect
// at the clock edge on which cfg_we is high and belong in idle time.
module mount_slew_and_homing_sequencer #(
    parameter int TIME_BITS = mshs_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mshs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mshs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic                              flip_needed,
    input  logic                              slew_done,
    input  logic                              position_synced,
    input  logic                              dec_blocked,
    input  logic                              ra_blocked,
    input  logic [31:0]                       now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              dec_cmd_valid,
    output logic                              dec_dir,
    output logic [3:0]                        dec_rate,
    output logic                              ra_cmd_valid,
    output logic                              ra_dir,
    output logic [3:0]                        ra_rate,
    output logic [1:0]                        goto_kind,
    output logic                              set_home,
    output logic                              busy_res,
    output logic                              is_aligned,
    output logic [3:0]                        phase
);
    import mshs_pkg::*;

    cfg_t                 cfg;
    item_t                item_reg;
    logic                 item_valid_reg;
    ctl_t                 ctl_reg;
    ctl_t                 ctl_next;
    logic [TIME_BITS-1:0] timer_reg;
    logic [TIME_BITS-1:0] timer_next;
    res_t                 res_next;
    res_t                 res_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 in_take;

    mshs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mshs_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item       (item_reg),
        .cfg        (cfg),
        .ctl        (ctl_reg),
        .timer      (timer_reg),
        .ctl_next   (ctl_next),
        .timer_next (timer_next),
        .res        (res_next)
    );

    // the registered request moves on whenever the result slot is free
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctl_reg        <= '{phase: PH_IDLE, ra_done: 1'b0, dec_stop: 1'b0,
                                seek_dir: 1'b0, aligned: 1'b0};
            timer_reg      <= '0;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                ctl_reg   <= ctl_next;
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode            <= mode;
            item_reg.flip_needed     <= flip_needed;
            item_reg.slew_done       <= slew_done;
            item_reg.position_synced <= position_synced;
            item_reg.dec_blocked     <= dec_blocked;
            item_reg.ra_blocked      <= ra_blocked;
            item_reg.now_ms          <= now_ms;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign dec_cmd_valid = res_reg.dec_cmd_valid;
    assign dec_dir       = res_reg.dec_dir;
    assign dec_rate      = res_reg.dec_rate;
    assign ra_cmd_valid  = res_reg.ra_cmd_valid;
    assign ra_dir        = res_reg.ra_dir;
    assign ra_rate       = res_reg.ra_rate;
    assign goto_kind     = res_reg.goto_kind;
    assign set_home      = res_reg.set_home;
    assign busy_res      = res_reg.busy_res;
    assign is_aligned    = res_reg.is_aligned;
    assign phase         = res_reg.phase;

endmodule
